// File: design/mm_pkg.sv
// Shared constants, types and helpers for the fixed-point matrix multiplier.
// No dependencies; mm_if, mm_ctrl, mm_mac and the top level use this package.
`default_nettype none
package mm_pkg;

    localparam int MAX_DIM  = 8;
    localparam int FIELD_W  = 3;                       // row / col field width on the ports
    localparam int CNT_W    = (MAX_DIM > 1) ? $clog2(MAX_DIM) : 1;
    localparam int CFG_W    = 4;
    localparam int KIND_W   = 2;
    localparam int DATA_W   = 32;
    localparam int FRAC_W   = 16;
    localparam int DEPTH    = MAX_DIM * MAX_DIM;
    localparam int ADDR_W   = $clog2(DEPTH);
    localparam int PROD_W   = 2 * DATA_W;
    localparam int ACC_W    = PROD_W + $clog2(MAX_DIM) + 1;

    localparam logic [CFG_W-1:0]         CFG_RESET  = 4'd8;
    localparam logic signed [ACC_W-1:0]  ROUND_HALF = ACC_W'(1) << (FRAC_W - 1);
    localparam logic signed [DATA_W-1:0] SAT_MAX    = {1'b0, {(DATA_W - 1){1'b1}}};
    localparam logic signed [DATA_W-1:0] SAT_MIN    = {1'b1, {(DATA_W - 1){1'b0}}};

    typedef enum logic [KIND_W-1:0] {
        KIND_LOAD_A = 2'd0,
        KIND_LOAD_B = 2'd1,
        KIND_START  = 2'd2
    } t_kind;

    typedef enum logic [1:0] {
        CFG_A_ROWS = 2'd0,
        CFG_A_COLS = 2'd1,
        CFG_B_ROWS = 2'd2,
        CFG_B_COLS = 2'd3
    } t_cfg_reg;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_ISSUE,
        ST_DRAIN,
        ST_ERR
    } t_state;

    // One inner-product step travelling down the multiply pipeline
    typedef struct packed {
        logic             vld;
        logic             first;
        logic             lastk;
        logic             last;
        logic [CNT_W-1:0] row;
        logic [CNT_W-1:0] col;
    } t_tag;

    typedef struct packed {
        logic [CFG_W-1:0] rows;
        logic [CFG_W-1:0] inner;
        logic [CFG_W-1:0] cols;
    } t_dims;

    typedef struct packed {
        logic start;
        logic mismatch;
        logic out_free;
        logic res_done;
    } t_ctrl_req;

    typedef struct packed {
        logic ready;
        logic err_beat;
    } t_ctrl_stat;

    typedef struct packed {
        logic                     vld;
        logic                     last;
        logic [CNT_W-1:0]         row;
        logic [CNT_W-1:0]         col;
        logic signed [DATA_W-1:0] product;
    } t_res;

    // Zero counts as one, anything above the store size as the store size
    function automatic logic [CFG_W-1:0] eff_dim(input logic [CFG_W-1:0] v);
        if (v == '0) begin
            return CFG_W'(1);
        end else if (v > CFG_W'(MAX_DIM)) begin
            return CFG_W'(MAX_DIM);
        end
        return v;
    endfunction

endpackage
`default_nettype wire

// File: design/mm_if.sv
// Valid/ready channel interfaces: command input and product output.
// Depends on mm_pkg for field widths.
`default_nettype none
interface mm_in_if;
    logic                              valid;
    logic                              ready;
    logic [mm_pkg::KIND_W-1:0]         kind;
    logic [mm_pkg::FIELD_W-1:0]        row;
    logic [mm_pkg::FIELD_W-1:0]        col;
    logic signed [mm_pkg::DATA_W-1:0]  value;

    modport source (output valid, kind, row, col, value, input ready);
    modport sink   (input valid, kind, row, col, value, output ready);
endinterface

interface mm_out_if;
    logic                              valid;
    logic                              ready;
    logic [mm_pkg::FIELD_W-1:0]        out_row;
    logic [mm_pkg::FIELD_W-1:0]        out_col;
    logic signed [mm_pkg::DATA_W-1:0]  product;
    logic                              last;
    logic                              error;

    modport source (output valid, out_row, out_col, product, last, error, input ready);
    modport sink   (input valid, out_row, out_col, product, last, error, output ready);
endinterface
`default_nettype wire

// File: design/matrix_multiply_top.sv
// Top level of the Q16.16 matrix multiplier: two element stores, sequencer,
// MAC pipeline, size registers and output register. Depends on mm_pkg, mm_if,
// mm_ram, mm_ctrl and mm_mac.
//
//  channel   dir   fields                                  beat
//  i_in      in    kind, row, col, value                   load A, load B or start
//  o_out     out   out_row, out_col, product, last, error  one product element
//  i_cfg_*   in    i_cfg_idx, i_cfg_data                   size register write
//
// A load beat writes one store entry. A start beat runs the whole product:
// each element steps the inner index through the single store read port and
// MAC, then flushes through the store read, product and accumulator
// registers; it starts only once the output register is free or draining.
// A size mismatch gives one error beat. New input beats are taken only
// between runs; the last element may still wait in the output register
// meanwhile. Reset is synchronous; store contents are not cleared.
`default_nettype none
module matrix_multiply_top (
    input  wire logic                      i_clk,
    input  wire logic                      i_rst_n,
    mm_in_if.sink                          i_in,
    mm_out_if.source                       o_out,
    input  wire logic                      i_cfg_we,
    input  wire logic [1:0]                i_cfg_idx,
    input  wire logic [mm_pkg::CFG_W-1:0]  i_cfg_data
);
    import mm_pkg::*;

    // Size registers
    logic [CFG_W-1:0] r_a_rows, r_a_cols, r_b_rows, r_b_cols;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_rows <= CFG_RESET;
            r_a_cols <= CFG_RESET;
            r_b_rows <= CFG_RESET;
            r_b_cols <= CFG_RESET;
        end else if (i_cfg_we) begin
            unique case (t_cfg_reg'(i_cfg_idx))
                CFG_A_ROWS: r_a_rows <= i_cfg_data;
                CFG_A_COLS: r_a_cols <= i_cfg_data;
                CFG_B_ROWS: r_b_rows <= i_cfg_data;
                CFG_B_COLS: r_b_cols <= i_cfg_data;
                default:    r_a_rows <= r_a_rows;
            endcase
        end
    end

    t_dims      w_dims;
    t_ctrl_req  w_req;
    t_ctrl_stat w_stat;
    t_tag       w_tag;
    t_res       w_res;

    logic              w_in_beat;
    logic              w_in_range;
    logic              w_we_a, w_we_b;
    logic [ADDR_W-1:0] w_waddr;
    logic [ADDR_W-1:0] w_raddr_a, w_raddr_b;
    logic [DATA_W-1:0] w_rdata_a, w_rdata_b;

    // Output register
    logic                     r_out_vld;
    logic [CNT_W-1:0]         r_out_row;
    logic [CNT_W-1:0]         r_out_col;
    logic signed [DATA_W-1:0] r_out_prod;
    logic                     r_out_last;
    logic                     r_out_err;

    assign w_dims.rows  = eff_dim(r_a_rows);
    assign w_dims.inner = eff_dim(r_a_cols);
    assign w_dims.cols  = eff_dim(r_b_cols);

    assign i_in.ready = w_stat.ready;
    assign w_in_beat  = i_in.valid && i_in.ready;

    // Loads outside the store are dropped
    assign w_in_range = ({1'b0, i_in.row} < (FIELD_W + 1)'(MAX_DIM)) &&
                        ({1'b0, i_in.col} < (FIELD_W + 1)'(MAX_DIM));
    assign w_waddr    = ADDR_W'(i_in.row) * ADDR_W'(MAX_DIM) + ADDR_W'(i_in.col);
    assign w_we_a     = w_in_beat && w_in_range && (i_in.kind == KIND_LOAD_A);
    assign w_we_b     = w_in_beat && w_in_range && (i_in.kind == KIND_LOAD_B);

    assign w_req.start    = w_in_beat && (i_in.kind == KIND_START);
    assign w_req.mismatch = (eff_dim(r_a_cols) != eff_dim(r_b_rows));
    assign w_req.out_free = !r_out_vld || o_out.ready;
    assign w_req.res_done = w_res.vld;

    mm_ram #(
        .WIDTH (DATA_W),
        .DEPTH (DEPTH)
    ) u_ram_a (
        .i_clk   (i_clk),
        .i_we    (w_we_a),
        .i_waddr (w_waddr),
        .i_wdata (i_in.value),
        .i_raddr (w_raddr_a),
        .o_rdata (w_rdata_a)
    );

    mm_ram #(
        .WIDTH (DATA_W),
        .DEPTH (DEPTH)
    ) u_ram_b (
        .i_clk   (i_clk),
        .i_we    (w_we_b),
        .i_waddr (w_waddr),
        .i_wdata (i_in.value),
        .i_raddr (w_raddr_b),
        .o_rdata (w_rdata_b)
    );

    mm_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_dims   (w_dims),
        .i_req    (w_req),
        .o_tag    (w_tag),
        .o_addr_a (w_raddr_a),
        .o_addr_b (w_raddr_b),
        .o_stat   (w_stat)
    );

    mm_mac u_mac (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_tag    (w_tag),
        .i_a_data (w_rdata_a),
        .i_b_data (w_rdata_b),
        .o_res    (w_res)
    );

    // The sequencer only starts an element when this register is free or
    // draining, so a finished element never finds it occupied.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (w_res.vld || w_stat.err_beat) begin
            r_out_vld <= 1'b1;
        end else if (o_out.ready) begin
            r_out_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_res.vld) begin
            r_out_row  <= w_res.row;
            r_out_col  <= w_res.col;
            r_out_prod <= w_res.product;
            r_out_last <= w_res.last;
            r_out_err  <= 1'b0;
        end else if (w_stat.err_beat) begin
            r_out_row  <= '0;
            r_out_col  <= '0;
            r_out_prod <= '0;
            r_out_last <= 1'b1;
            r_out_err  <= 1'b1;
        end
    end

    assign o_out.valid   = r_out_vld;
    assign o_out.out_row = FIELD_W'(r_out_row);
    assign o_out.out_col = FIELD_W'(r_out_col);
    assign o_out.product = r_out_prod;
    assign o_out.last    = r_out_last;
    assign o_out.error   = r_out_err;

endmodule
`default_nettype wire

// File: design/mm_ram.sv
// Generic simple dual-port RAM: one write port, one read port, registered read.
// No dependencies.
`default_nettype none
module mm_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output      logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule
`default_nettype wire

// File: design/mm_ctrl.sv
// Run sequencer: walks output rows, columns and the inner index, drives store reads.
// Depends on mm_pkg.
`default_nettype none
module mm_ctrl (
    input  wire logic                      i_clk,
    input  wire logic                      i_rst_n,
    input  wire mm_pkg::t_dims             i_dims,
    input  wire mm_pkg::t_ctrl_req         i_req,
    output      mm_pkg::t_tag              o_tag,
    output      logic [mm_pkg::ADDR_W-1:0] o_addr_a,
    output      logic [mm_pkg::ADDR_W-1:0] o_addr_b,
    output      mm_pkg::t_ctrl_stat        o_stat
);
    import mm_pkg::*;

    t_state           r_state, n_state;
    logic [CNT_W-1:0] r_i, n_i;
    logic [CNT_W-1:0] r_j, n_j;
    logic [CNT_W-1:0] r_k, n_k;
    logic             w_i_last, w_j_last, w_k_last;

    assign w_i_last = (CFG_W'(r_i) == i_dims.rows  - CFG_W'(1));
    assign w_j_last = (CFG_W'(r_j) == i_dims.cols  - CFG_W'(1));
    assign w_k_last = (CFG_W'(r_k) == i_dims.inner - CFG_W'(1));

    assign o_addr_a = ADDR_W'(r_i) * ADDR_W'(MAX_DIM) + ADDR_W'(r_k);
    assign o_addr_b = ADDR_W'(r_k) * ADDR_W'(MAX_DIM) + ADDR_W'(r_j);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_i     <= '0;
            r_j     <= '0;
            r_k     <= '0;
        end else begin
            r_state <= n_state;
            r_i     <= n_i;
            r_j     <= n_j;
            r_k     <= n_k;
        end
    end

    always_comb begin
        n_state = r_state;
        n_i     = r_i;
        n_j     = r_j;
        n_k     = r_k;
        o_tag   = '0;
        o_stat  = '0;
        unique case (r_state)
            ST_IDLE: begin
                o_stat.ready = 1'b1;
                if (i_req.start) begin
                    n_i     = '0;
                    n_j     = '0;
                    n_k     = '0;
                    n_state = i_req.mismatch ? ST_ERR : ST_ISSUE;
                end
            end
            ST_ISSUE: begin
                // hold the first step until the output slot can take this element
                if (r_k != '0 || i_req.out_free) begin
                    o_tag.vld   = 1'b1;
                    o_tag.first = (r_k == '0);
                    o_tag.lastk = w_k_last;
                    o_tag.last  = w_i_last && w_j_last;
                    o_tag.row   = r_i;
                    o_tag.col   = r_j;
                    if (w_k_last) begin
                        n_k     = '0;
                        n_state = ST_DRAIN;
                    end else begin
                        n_k = r_k + 1'b1;
                    end
                end
            end
            ST_DRAIN: begin
                if (i_req.res_done) begin
                    if (w_i_last && w_j_last) begin
                        n_state = ST_IDLE;
                    end else begin
                        n_state = ST_ISSUE;
                        if (w_j_last) begin
                            n_j = '0;
                            n_i = r_i + 1'b1;
                        end else begin
                            n_j = r_j + 1'b1;
                        end
                    end
                end
            end
            ST_ERR: begin
                if (i_req.out_free) begin
                    o_stat.err_beat = 1'b1;
                    n_state         = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

endmodule
`default_nettype wire

// File: design/mm_mac.sv
// Multiply-accumulate pipeline: product register, wide exact accumulator,
// round-to-nearest and saturation to Q16.16. Depends on mm_pkg.
`default_nettype none
module mm_mac (
    input  wire logic                             i_clk,
    input  wire logic                             i_rst_n,
    input  wire mm_pkg::t_tag                     i_tag,
    input  wire logic signed [mm_pkg::DATA_W-1:0] i_a_data,
    input  wire logic signed [mm_pkg::DATA_W-1:0] i_b_data,
    output      mm_pkg::t_res                     o_res
);
    import mm_pkg::*;

    t_tag                     r_tag1, r_tag2, r_tag3;
    logic signed [PROD_W-1:0] r_prod;
    logic signed [ACC_W-1:0]  r_acc;
    logic signed [ACC_W-1:0]  w_rnd;
    logic [ACC_W-FRAC_W-DATA_W:0] w_hi;
    logic                     w_fits;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tag1 <= '0;
            r_tag2 <= '0;
            r_tag3 <= '0;
        end else begin
            r_tag1 <= i_tag;
            r_tag2 <= r_tag1;
            r_tag3 <= r_tag2;
        end
    end

    // store data lines up with r_tag1; product lines up with r_tag2
    always_ff @(posedge i_clk) begin
        r_prod <= i_a_data * i_b_data;
        if (r_tag2.vld) begin
            r_acc <= (r_tag2.first ? ACC_W'(0) : r_acc) + ACC_W'(r_prod);
        end
    end

    assign w_rnd  = r_acc + ROUND_HALF;
    assign w_hi   = w_rnd[ACC_W-1:FRAC_W+DATA_W-1];
    assign w_fits = (&w_hi) || !(|w_hi);

    always_comb begin
        o_res.vld  = r_tag3.vld && r_tag3.lastk;
        o_res.last = r_tag3.last;
        o_res.row  = r_tag3.row;
        o_res.col  = r_tag3.col;
        if (w_fits) begin
            o_res.product = w_rnd[FRAC_W+DATA_W-1:FRAC_W];
        end else begin
            o_res.product = w_rnd[ACC_W-1] ? SAT_MIN : SAT_MAX;
        end
    end

endmodule
`default_nettype wire

// File: sim/matrix_multiply_top_tb.sv
`timescale 1ns / 1ps
// Self-checking bench for matrix_multiply_top: loads both element stores, runs
// products of many sizes and checks every output beat against a local model.
// Depends on mm_pkg, the mm_in_if / mm_out_if channels and the design files.
module matrix_multiply_top_tb;
    import mm_pkg::*;

    localparam int CLK_PERIOD    = 4;
    localparam int RAND_ITEMS    = 190;        // loads and starts in the random part
    localparam int CALM_TAIL     = 40;         // last items run with no stalls on either side
    localparam int SETTLE_CYCLES = 12;         // quiet cycles before a size write and at the end
    localparam int LIMIT_NS      = 10_000_000;
    localparam int NPLAN         = 23;

    // Kind code the block must swallow without a beat out
    localparam logic [KIND_W-1:0] KIND_SPARE = 2'd3;

    // One product element as it should appear on the output channel
    typedef struct packed {
        logic [FIELD_W-1:0]        row;
        logic [FIELD_W-1:0]        col;
        logic signed [DATA_W-1:0]  product;
        logic                      last;
        logic                      error;
    } t_elem;

    // One line of the directed table; dims packs {a_rows, a_cols, b_rows, b_cols}
    typedef struct packed {
        logic                  new_dims;
        logic [4*CFG_W-1:0]    dims;
        logic [KIND_W-1:0]     kind;
        logic [FIELD_W-1:0]    row;
        logic [FIELD_W-1:0]    col;
        logic [DATA_W-1:0]     value;
        logic                  typed;
        t_elem                 want;
    } t_plan_row;

    logic i_clk = 1'b0;
    logic i_rst_n;
    logic               i_cfg_we;
    logic [1:0]         i_cfg_idx;
    logic [CFG_W-1:0]   i_cfg_data;

    mm_in_if  in_ch ();
    mm_out_if out_ch ();

    matrix_multiply_top dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in       (in_ch),
        .o_out      (out_ch),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data)
    );

    always #(CLK_PERIOD / 2) i_clk = ~i_clk;

    // ------------------------------------------------------------------
    // Local copy of the block: both stores, which entries hold data, and
    // the four size registers. Products still owed sit in pending_products.
    // ------------------------------------------------------------------
    logic signed [DATA_W-1:0] left_mat  [DEPTH];
    logic signed [DATA_W-1:0] right_mat [DEPTH];
    bit                       left_set  [DEPTH];
    bit                       right_set [DEPTH];
    logic [CFG_W-1:0]         dim_reg   [4];
    t_elem                    pending_products [$];

    int  mismatch_count = 0;
    int  rand_items     = 0;
    bit  did_full       = 1'b0;
    bit  stall_on       = 1'b1;    // idle bursts allowed in this phase
    bit  quiet          = 1'b0;    // closing stretch: no idling at all

    t_plan_row plan [NPLAN];

    // A size of zero behaves as one, anything past the store edge as the edge
    function automatic int counted_dim(input logic [CFG_W-1:0] raw);
        if (raw == '0) begin
            return 1;
        end
        if (raw > MAX_DIM) begin
            return MAX_DIM;
        end
        return int'(raw);
    endfunction

    // Work out every element owed for one start, or the single error beat
    task automatic push_product_grid();
        int                  ar, ac, br, bc;
        logic signed [63:0]  term;
        logic signed [71:0]  acc;
        logic signed [71:0]  rounded;
        t_elem               e;
        ar = counted_dim(dim_reg[CFG_A_ROWS]);
        ac = counted_dim(dim_reg[CFG_A_COLS]);
        br = counted_dim(dim_reg[CFG_B_ROWS]);
        bc = counted_dim(dim_reg[CFG_B_COLS]);
        if (ac != br) begin
            e.row     = '0;
            e.col     = '0;
            e.product = '0;
            e.last    = 1'b1;
            e.error   = 1'b1;
            pending_products.push_back(e);
            return;
        end
        for (int i = 0; i < ar; i++) begin
            for (int j = 0; j < bc; j++) begin
                // Exact Q32.32 sum, one rounding step, then clamp
                acc = '0;
                for (int k = 0; k < ac; k++) begin
                    term = left_mat[i * MAX_DIM + k] * right_mat[k * MAX_DIM + j];
                    acc += term;
                end
                rounded = (acc + (72'sd1 <<< (FRAC_W - 1))) >>> FRAC_W;
                if (rounded > SAT_MAX) begin
                    e.product = SAT_MAX;
                end else if (rounded < SAT_MIN) begin
                    e.product = SAT_MIN;
                end else begin
                    e.product = rounded[DATA_W-1:0];
                end
                e.row   = FIELD_W'(i);
                e.col   = FIELD_W'(j);
                e.last  = (i == ar - 1) && (j == bc - 1);
                e.error = 1'b0;
                pending_products.push_back(e);
            end
        end
    endtask

    // Apply one accepted input beat to the local copy
    task automatic mirror_beat(input logic [KIND_W-1:0] kind, input logic [FIELD_W-1:0] row,
                               input logic [FIELD_W-1:0] col, input logic [DATA_W-1:0] value,
                               input bit typed, input t_elem want);
        int idx;
        idx = row * MAX_DIM + col;
        case (kind)
            KIND_LOAD_A: begin
                left_mat[idx] = value;
                left_set[idx] = 1'b1;
            end
            KIND_LOAD_B: begin
                right_mat[idx] = value;
                right_set[idx] = 1'b1;
            end
            KIND_START: begin
                if (typed) begin
                    pending_products.push_back(want);
                end else begin
                    push_product_grid();
                end
            end
            default: ;
        endcase
    endtask

    task automatic flag_mismatch(input string what, input logic [DATA_W-1:0] got,
                                 input logic [DATA_W-1:0] want);
        $display("%0t ns: mismatch on %s: got %h, want %h", $time, what, got, want);
        mismatch_count++;
    endtask

    // ------------------------------------------------------------------
    // Input side. Every task below is entered and left on a rising edge.
    // ------------------------------------------------------------------

    // Offer one beat and hold it until the block takes it. Valid is left
    // high on return so back-to-back beats never drop it within a step.
    task automatic send_beat(input logic [KIND_W-1:0] kind, input logic [FIELD_W-1:0] row,
                             input logic [FIELD_W-1:0] col, input logic [DATA_W-1:0] value,
                             input bit typed, input t_elem want);
        if (stall_on && !quiet && $urandom_range(0, 5) == 0) begin
            in_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 10)) @(posedge i_clk);
        end
        in_ch.valid <= 1'b1;
        in_ch.kind  <= kind;
        in_ch.row   <= row;
        in_ch.col   <= col;
        in_ch.value <= value;
        do @(posedge i_clk); while (!in_ch.ready);
        mirror_beat(kind, row, col, value, typed, want);
    endtask

    // Hold off the sender until every owed product is out, then let the
    // pipeline go quiet. Also serves as the full-drain pause on the input.
    task automatic drain_and_settle();
        in_ch.valid <= 1'b0;
        while (pending_products.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_reg(input t_cfg_reg idx, input logic [CFG_W-1:0] data);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= data;
        dim_reg[idx] = data;
        @(posedge i_clk);
    endtask

    task automatic write_dims(input logic [4*CFG_W-1:0] dims);
        write_reg(CFG_A_ROWS, dims[4*CFG_W-1 -: CFG_W]);
        write_reg(CFG_A_COLS, dims[3*CFG_W-1 -: CFG_W]);
        write_reg(CFG_B_ROWS, dims[2*CFG_W-1 -: CFG_W]);
        write_reg(CFG_B_COLS, dims[CFG_W-1 -: CFG_W]);
        i_cfg_we <= 1'b0;
    endtask

    function automatic t_plan_row plan_step(input logic new_dims, input logic [4*CFG_W-1:0] dims,
                                            input logic [KIND_W-1:0] kind,
                                            input logic [FIELD_W-1:0] row,
                                            input logic [FIELD_W-1:0] col,
                                            input logic [DATA_W-1:0] value, input logic typed,
                                            input logic [DATA_W-1:0] product, input logic error);
        t_plan_row p;
        p.new_dims     = new_dims;
        p.dims         = dims;
        p.kind         = kind;
        p.row          = row;
        p.col          = col;
        p.value        = value;
        p.typed        = typed;
        p.want.row     = '0;
        p.want.col     = '0;
        p.want.product = product;
        p.want.last    = 1'b1;
        p.want.error   = error;
        return p;
    endfunction

    // Mix of full-range words, rails and small Q16.16 values near zero
    function automatic logic [DATA_W-1:0] rand_value();
        case ($urandom_range(0, 4))
            0: return $urandom();
            1: begin
                case ($urandom_range(0, 4))
                    0: return 32'h7FFF_FFFF;
                    1: return 32'h8000_0000;
                    2: return 32'h0000_0000;
                    3: return 32'hFFFF_FFFF;
                    default: return 32'h0001_0000;
                endcase
            end
            default: return DATA_W'($urandom_range(0, 32'h0008_0000)) - 32'h0004_0000;
        endcase
    endfunction

    function automatic logic [CFG_W-1:0] pick_dim();
        case ($urandom_range(0, 9))
            0: return '0;
            1: return CFG_W'($urandom_range(MAX_DIM + 1, 15));
            2: return CFG_W'($urandom_range(5, MAX_DIM));
            default: return CFG_W'($urandom_range(1, 4));
        endcase
    endfunction

    // A raw size that counts the same as raw, often spelled differently
    function automatic logic [CFG_W-1:0] twin_dim(input logic [CFG_W-1:0] raw);
        case (counted_dim(raw))
            1: return CFG_W'($urandom_range(0, 1));
            MAX_DIM: return CFG_W'($urandom_range(MAX_DIM, 15));
            default: return raw;
        endcase
    endfunction

    function automatic bit needed_written(input int ar, input int ac, input int bc);
        for (int k = 0; k < ac; k++) begin
            for (int i = 0; i < ar; i++) begin
                if (!left_set[i * MAX_DIM + k]) begin
                    return 1'b0;
                end
            end
            for (int j = 0; j < bc; j++) begin
                if (!right_set[k * MAX_DIM + j]) begin
                    return 1'b0;
                end
            end
        end
        return 1'b1;
    endfunction

    task automatic send_stray_load();
        send_beat($urandom_range(0, 1) ? KIND_LOAD_B : KIND_LOAD_A, FIELD_W'($urandom()),
                  FIELD_W'($urandom()), rand_value(), 1'b0, '0);
        rand_items++;
    endtask

    // Sprinkle ignored kinds and loads to arbitrary spots into a sequence
    task automatic inject_noise();
        case ($urandom_range(0, 11))
            0: send_beat(KIND_SPARE, FIELD_W'($urandom()), FIELD_W'($urandom()), $urandom(),
                         1'b0, '0);
            1: send_stray_load();
            default: ;
        endcase
    endtask

    task automatic send_start();
        send_beat(KIND_START, FIELD_W'($urandom()), FIELD_W'($urandom()), $urandom(), 1'b0, '0);
        rand_items++;
    endtask

    // One random phase: pick sizes, write them while idle, fill whatever the
    // product reads (shuffled, with noise), then start it; on a size mismatch, stray loads and a start.
    task automatic run_random_phase();
        logic [CFG_W-1:0] d_ar, d_ac, d_br, d_bc;
        int               ar, ac, br, bc, pick;
        logic [6:0]       loads [$];
        logic [6:0]       tmp;
        if (!did_full && rand_items >= 60) begin
            // One run at the largest size; the rest stay mostly small
            d_ar = CFG_W'(MAX_DIM);
            d_ac = CFG_W'(MAX_DIM);
            d_br = CFG_W'(MAX_DIM);
            d_bc = CFG_W'(MAX_DIM);
            did_full = 1'b1;
        end else begin
            d_ar = pick_dim();
            d_ac = pick_dim();
            d_bc = pick_dim();
            d_br = ($urandom_range(0, 6) == 0) ? pick_dim() : twin_dim(d_ac);
        end
        drain_and_settle();
        write_dims({d_ar, d_ac, d_br, d_bc});
        stall_on = ($urandom_range(0, 3) != 0);
        ar = counted_dim(d_ar);
        ac = counted_dim(d_ac);
        br = counted_dim(d_br);
        bc = counted_dim(d_bc);
        if (ac == br) begin
            // Load every entry never written, and refresh about a third of the rest
            for (int i = 0; i < ar; i++) begin
                for (int k = 0; k < ac; k++) begin
                    if (!left_set[i * MAX_DIM + k] || $urandom_range(0, 2) == 0) begin
                        loads.push_back({1'b0, FIELD_W'(i), FIELD_W'(k)});
                    end
                end
            end
            for (int k = 0; k < ac; k++) begin
                for (int j = 0; j < bc; j++) begin
                    if (!right_set[k * MAX_DIM + j] || $urandom_range(0, 2) == 0) begin
                        loads.push_back({1'b1, FIELD_W'(k), FIELD_W'(j)});
                    end
                end
            end
            for (int n = loads.size() - 1; n > 0; n--) begin
                pick = $urandom_range(0, n);
                tmp = loads[n];
                loads[n] = loads[pick];
                loads[pick] = tmp;
            end
            while (loads.size() != 0) begin
                inject_noise();
                tmp = loads.pop_front();
                send_beat(tmp[6] ? KIND_LOAD_B : KIND_LOAD_A, tmp[5:3], tmp[2:0], rand_value(),
                          1'b0, '0);
                rand_items++;
                // Cut in with an early start once everything it reads holds data
                if (loads.size() != 0 && $urandom_range(0, 11) == 0
                        && needed_written(ar, ac, bc)) begin
                    send_start();
                end
            end
            inject_noise();
            send_start();
            if ($urandom_range(0, 3) == 0) begin
                send_start();
            end
        end else begin
            // Sizes disagree: a few loads, then a start that must come back as an error
            repeat ($urandom_range(0, 3)) send_stray_load();
            send_start();
        end
        quiet = (rand_items >= RAND_ITEMS - CALM_TAIL);
    endtask

    // ------------------------------------------------------------------
    // Main sequence: reset, directed table, random phases, drain, verdict.
    // ------------------------------------------------------------------
    initial begin
        in_ch.valid <= 1'b0;
        in_ch.kind  <= KIND_LOAD_A;
        in_ch.row   <= '0;
        in_ch.col   <= '0;
        in_ch.value <= '0;
        i_cfg_we    <= 1'b0;
        i_cfg_idx   <= CFG_A_ROWS;
        i_cfg_data  <= '0;
        i_rst_n     <= 1'b0;
        for (int r = 0; r < 4; r++) begin
            dim_reg[r] = CFG_RESET;
        end

        // 1x1 runs cover the arithmetic corners: plain product, both rails,
        // rounding of an exact half up and of a negative half to zero.
        plan[0]  = plan_step(1'b1, 16'h1111, KIND_LOAD_A, 3'd0, 3'd0, 32'h0001_0000, 0, '0, 0);
        plan[1]  = plan_step(1'b0, '0, KIND_LOAD_B, 3'd0, 3'd0, 32'h0002_0000, 0, '0, 0);
        plan[2]  = plan_step(1'b0, '0, KIND_START, 3'd0, 3'd0, '0, 1, 32'h0002_0000, 0);
        plan[3]  = plan_step(1'b0, '0, KIND_LOAD_A, 3'd0, 3'd0, 32'h7FFF_FFFF, 0, '0, 0);
        plan[4]  = plan_step(1'b0, '0, KIND_LOAD_B, 3'd0, 3'd0, 32'h7FFF_FFFF, 0, '0, 0);
        plan[5]  = plan_step(1'b0, '0, KIND_START, 3'd7, 3'd7, '1, 1, 32'h7FFF_FFFF, 0);
        plan[6]  = plan_step(1'b0, '0, KIND_LOAD_B, 3'd0, 3'd0, 32'h8000_0000, 0, '0, 0);
        plan[7]  = plan_step(1'b0, '0, KIND_START, 3'd0, 3'd0, '0, 1, 32'h8000_0000, 0);
        plan[8]  = plan_step(1'b0, '0, KIND_LOAD_A, 3'd0, 3'd0, 32'h8000_0000, 0, '0, 0);
        plan[9]  = plan_step(1'b0, '0, KIND_START, 3'd0, 3'd0, '0, 1, 32'h7FFF_FFFF, 0);
        plan[10] = plan_step(1'b0, '0, KIND_LOAD_A, 3'd0, 3'd0, 32'h0000_0001, 0, '0, 0);
        plan[11] = plan_step(1'b0, '0, KIND_LOAD_B, 3'd0, 3'd0, 32'h0000_8000, 0, '0, 0);
        plan[12] = plan_step(1'b0, '0, KIND_START, 3'd0, 3'd0, '0, 1, 32'h0000_0001, 0);
        plan[13] = plan_step(1'b0, '0, KIND_LOAD_A, 3'd0, 3'd0, 32'hFFFF_FFFF, 0, '0, 0);
        plan[14] = plan_step(1'b0, '0, KIND_START, 3'd0, 3'd0, '0, 1, 32'h0000_0000, 0);
        // Unused kind: swallowed, nothing comes out
        plan[15] = plan_step(1'b0, '0, KIND_SPARE, 3'd7, 3'd7, 32'hA5A5_5A5A, 0, '0, 0);
        // All sizes zero behave as 1x1
        plan[16] = plan_step(1'b1, 16'h0000, KIND_START, 3'd0, 3'd0, '0, 1, 32'h0000_0000, 0);
        // Inner sizes disagree: plain, zero against two, fifteen against seven
        plan[17] = plan_step(1'b1, 16'h1231, KIND_START, 3'd0, 3'd0, '0, 1, '0, 1);
        plan[18] = plan_step(1'b1, 16'h2022, KIND_START, 3'd0, 3'd0, '0, 1, '0, 1);
        plan[19] = plan_step(1'b1, 16'h1F71, KIND_START, 3'd0, 3'd0, '0, 1, '0, 1);
        // Far corner of both stores, with every size register at its top; then a start with mismatched inner sizes
        plan[20] = plan_step(1'b1, 16'hFFFF, KIND_LOAD_A, 3'd7, 3'd7, 32'h7FFF_FFFF, 0, '0, 0);
        plan[21] = plan_step(1'b0, '0, KIND_LOAD_B, 3'd7, 3'd7, 32'h8000_0000, 0, '0, 0);
        plan[22] = plan_step(1'b1, 16'hF0F0, KIND_START, 3'd0, 3'd0, '0, 1, '0, 1);

        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        for (int n = 0; n < NPLAN; n++) begin
            if (plan[n].new_dims) begin
                drain_and_settle();
                write_dims(plan[n].dims);
            end
            send_beat(plan[n].kind, plan[n].row, plan[n].col, plan[n].value, plan[n].typed,
                      plan[n].want);
        end

        while (rand_items < RAND_ITEMS) begin
            run_random_phase();
        end

        drain_and_settle();
        if (mismatch_count == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

    // Output side: drop ready in random bursts unless the phase runs calm
    initial begin
        out_ch.ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (stall_on && !quiet && $urandom_range(0, 5) == 0) begin
                out_ch.ready <= 1'b0;
                repeat ($urandom_range(1, 10)) @(posedge i_clk);
            end
            out_ch.ready <= 1'b1;
        end
    end

    // Compare every output beat with the oldest owed element, field by field
    always @(posedge i_clk) begin
        t_elem due;
        if (i_rst_n && out_ch.valid && out_ch.ready) begin
            if (pending_products.size() == 0) begin
                flag_mismatch("unexpected beat", out_ch.product, '0);
            end else begin
                due = pending_products.pop_front();
                if (out_ch.out_row !== due.row) begin
                    flag_mismatch("out_row", DATA_W'(out_ch.out_row), DATA_W'(due.row));
                end
                if (out_ch.out_col !== due.col) begin
                    flag_mismatch("out_col", DATA_W'(out_ch.out_col), DATA_W'(due.col));
                end
                if (out_ch.product !== due.product) begin
                    flag_mismatch("product", out_ch.product, due.product);
                end
                if (out_ch.last !== due.last) begin
                    flag_mismatch("last", DATA_W'(out_ch.last), DATA_W'(due.last));
                end
                if (out_ch.error !== due.error) begin
                    flag_mismatch("error", DATA_W'(out_ch.error), DATA_W'(due.error));
                end
            end
        end
    end

    // Hard stop well past the slowest correct run
    initial begin
        #(LIMIT_NS);
        $display("TEST FAILED");
        $finish;
    end

endmodule

// File: files.f
design/mm_pkg.sv
design/mm_if.sv
design/mm_ram.sv
design/mm_ctrl.sv
design/mm_mac.sv
design/matrix_multiply_top.sv
sim/matrix_multiply_top_tb.sv
